// ----- hw/rtl/radar_clutter_map_accumulator_top_defines.svh -----
// Assertion macros for the clutter map accumulator.
`ifndef RADAR_CLUTTER_MAP_ACCUMULATOR_TOP_DEFINES_SVH
`define RADAR_CLUTTER_MAP_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RCM_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define RCM_ASSERT(label, clk, rst_n, prop)
`define RCM_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/rcm_pkg.sv -----
// Shared types and constants for the clutter map accumulator.
package rcm_pkg;
    localparam logic [2:0] ACT_SAMPLE = 3'd0;
    localparam logic [2:0] ACT_MERGE  = 3'd1;
    localparam logic [2:0] ACT_SCAN   = 3'd2;
    localparam logic [2:0] ACT_READ   = 3'd3;
    localparam logic [2:0] ACT_CLRSC  = 3'd4;

    localparam logic [2:0] REG_QEN  = 3'd0;
    localparam logic [2:0] REG_SNR  = 3'd1;
    localparam logic [2:0] REG_VEL  = 3'd2;
    localparam logic [2:0] REG_WID  = 3'd3;
    localparam logic [2:0] REG_FRAC = 3'd4;
    localparam logic [2:0] REG_MINS = 3'd5;
    localparam logic [2:0] REG_MODE = 3'd6;

    typedef struct packed {
        logic [2:0]  qen;
        logic signed [15:0] min_snr;
        logic [14:0] max_vel;
        logic [15:0] max_wid;
        logic [15:0] min_frac;
        logic [12:0] min_scans;
        logic        imode;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] gate_index;
        logic signed [15:0] reflectivity;
        logic        reflectivity_missing;
        logic signed [15:0] gate_threshold;
        logic signed [15:0] snr;
        logic        snr_missing;
        logic signed [15:0] velocity;
        logic [15:0] spectrum_width;
        logic [12:0] partial_count;
    } item_t;

    typedef struct packed {
        logic [15:0] out_gate;
        logic [12:0] hit_count;
        logic signed [15:0] mean_reflectivity;
        logic        mean_valid;
        logic [15:0] hit_fraction;
        logic        too_few_scans;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;   // clearing sweep write
        logic load;       // capture item, issue memory read
        logic update;     // write back sample/merge/read-clear
        logic div_start;
        logic res_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic div_busy;
    } status_t;
endpackage

// ----- hw/rtl/rcm_if.sv -----
// Valid/ready stream interfaces for items and results.
interface rcm_item_if;
    import rcm_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rcm_result_if;
    import rcm_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rcm_ctrl.sv -----
// Sequencer for clearing, item processing, division and result transfer.
module rcm_ctrl
    import rcm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic [2:0] in_action,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t stat,
    output cmd_t    cmd
);
    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_UPD, S_DIV, S_OUT} state_t;
    state_t state_reg, state_next;
    logic read_reg, read_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        read_next = read_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        in_ready = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (in_valid && !out_valid_reg)
                begin
                    cmd.load = 1'b1;
                    read_next = (in_action == ACT_READ);
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_UPD;
            S_UPD:
            begin
                cmd.update = 1'b1;
                if (read_reg)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_IDLE;
            end
            S_DIV:
                if (!stat.div_busy)
                begin
                    cmd.res_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_OUT;
                end
            S_OUT:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            read_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            read_reg <= read_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ----- hw/rtl/rcm_datapath.sv -----
// Gate memories, qualifier tests, scan counter and readout arithmetic.
module rcm_datapath
    import rcm_pkg::*;
#(
    parameter int GATE_COUNT = 65536,
    parameter int MAX_SCANS  = 4096
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  cfg_t    cfg,
    input  item_t   item,
    output status_t stat,
    output result_t res
);
    localparam int AW = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
    localparam logic [12:0] LIMIT = (MAX_SCANS > 8191) ? 13'd8191 : 13'(MAX_SCANS);

    logic [12:0] hits_mem [GATE_COUNT];
    logic signed [31:0] sum_mem [GATE_COUNT];

    item_t it_reg;
    logic [AW:0] clr_reg;
    logic [12:0] scan_reg;
    logic [12:0] hrd_reg;
    logic signed [31:0] srd_reg;
    logic in_range;
    logic [AW-1:0] addr;

    assign in_range = {5'd0, it_reg.gate_index} < 21'(GATE_COUNT);
    assign addr = AW'(it_reg.gate_index);
    assign stat.clr_done = clr_reg[AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step && !clr_reg[AW])
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
        if (cmd.load)
            it_reg <= item;

    always_ff @(posedge clk)
    begin
        hrd_reg <= hits_mem[addr];
        srd_reg <= sum_mem[addr];
    end

    // qualifier
    logic qual;
    logic [15:0] avel;
    always_comb
    begin
        avel = it_reg.velocity[15] ? 16'(-it_reg.velocity) : it_reg.velocity;
        qual = in_range && !it_reg.reflectivity_missing;
        if (cfg.qen[0])
        begin
            if (it_reg.snr_missing || it_reg.snr < cfg.min_snr)
                qual = 1'b0;
        end
        else if (it_reg.reflectivity < it_reg.gate_threshold)
            qual = 1'b0;
        if (cfg.qen[1] && avel > {1'b0, cfg.max_vel})
            qual = 1'b0;
        if (cfg.qen[2] && it_reg.spectrum_width > cfg.max_wid)
            qual = 1'b0;
        if (hrd_reg >= LIMIT)
            qual = 1'b0;
    end

    logic [13:0] msum;
    logic [12:0] mnow, madd;
    logic signed [31:0] mprod;
    assign msum = {1'b0, hrd_reg} + {1'b0, it_reg.partial_count};
    assign mnow = (msum > {1'b0, LIMIT}) ? LIMIT : msum[12:0];
    assign madd = mnow - hrd_reg;
    assign mprod = 32'(it_reg.reflectivity) * 32'($signed({1'b0, madd}));

    logic [13:0] ssum;
    assign ssum = {1'b0, scan_reg} + {1'b0, it_reg.partial_count};

    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [12:0] wr_h;
    logic signed [31:0] wr_s;
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = addr;
        wr_h = '0;
        wr_s = '0;
        if (cmd.clr_step && !clr_reg[AW])
        begin
            wr_en = 1'b1;
            wr_addr = clr_reg[AW-1:0];
        end
        else if (cmd.update && in_range)
        begin
            case (it_reg.action)
                ACT_SAMPLE:
                begin
                    wr_en = qual;
                    wr_h = hrd_reg + 13'd1;
                    wr_s = srd_reg + 32'(it_reg.reflectivity);
                end
                ACT_MERGE:
                begin
                    wr_en = !it_reg.reflectivity_missing;
                    wr_h = mnow;
                    wr_s = srd_reg + mprod;
                end
                ACT_READ:
                    wr_en = 1'b1;
                default:
                    wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
        if (wr_en)
        begin
            hits_mem[wr_addr] <= wr_h;
            sum_mem[wr_addr] <= wr_s;
        end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_reg <= '0;
        else if (cmd.update)
        begin
            if (it_reg.action == ACT_SCAN)
                scan_reg <= (ssum > {1'b0, LIMIT}) ? LIMIT : ssum[12:0];
            else if (it_reg.action == ACT_CLRSC)
                scan_reg <= '0;
        end
    end

    // shared restoring divider, two quotients one after another:
    // fraction = (n<<16)/scans, mean = (2|s|+n)/(2n)
    logic        dbusy_reg;
    logic        phase_reg;  // 0 fraction, 1 mean
    logic [5:0]  cnt_reg;
    logic [33:0] rem_reg;
    logic [33:0] num_reg;
    logic [33:0] den_reg;
    logic [33:0] quo_reg;
    logic [12:0] n_reg;
    logic        neg_reg;
    logic [33:0] mag_reg;
    logic [16:0] frac_q_reg;
    logic [33:0] trial;
    logic [33:0] shifted;

    assign shifted = {rem_reg[32:0], num_reg[33]};
    assign trial = shifted - den_reg;
    assign stat.div_busy = dbusy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= 1'b1;
            phase_reg <= 1'b0;
            cnt_reg <= 6'd34;
        end
        else if (dbusy_reg)
        begin
            if (cnt_reg == 6'd1)
            begin
                if (!phase_reg)
                begin
                    phase_reg <= 1'b1;
                    cnt_reg <= 6'd34;
                end
                else
                    dbusy_reg <= 1'b0;
            end
            else
                cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            n_reg <= in_range ? hrd_reg : 13'd0;
            neg_reg <= in_range && srd_reg[31];
            mag_reg <= in_range ? (srd_reg[31] ? 34'(-srd_reg) : 34'(srd_reg)) : '0;
            num_reg <= {5'd0, (in_range ? hrd_reg : 13'd0), 16'd0};
            den_reg <= (scan_reg == '0) ? 34'd1 : {21'd0, scan_reg};
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            if (cnt_reg == 6'd1 && !phase_reg)
            begin
                frac_q_reg <= (quo_reg[32:15] != '0) ? 17'h1ffff
                    : {1'b0, quo_reg[14:0], ~trial[33]};
                num_reg <= (mag_reg << 1) + {21'd0, n_reg};
                den_reg <= (n_reg == '0) ? 34'd2 : {20'd0, n_reg, 1'b0};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else
            begin
                rem_reg <= trial[33] ? shifted : trial;
                quo_reg <= {quo_reg[32:0], ~trial[33]};
                num_reg <= {num_reg[32:0], 1'b0};
            end
        end
    end

    // result assembly
    logic [15:0] frac;
    logic few, valid;
    logic [15:0] qmag;
    always_comb
    begin
        frac = (scan_reg == '0) ? 16'd0 :
            (frac_q_reg[16] ? 16'hffff : frac_q_reg[15:0]);
        qmag = quo_reg[15:0];
        if (cfg.imode)
        begin
            few = 1'b0;
            valid = n_reg != '0;
        end
        else
        begin
            few = scan_reg < cfg.min_scans;
            valid = n_reg != '0 && !few && frac >= cfg.min_frac;
        end
    end

    always_ff @(posedge clk)
        if (cmd.res_load)
        begin
            res.out_gate <= it_reg.gate_index;
            res.hit_count <= n_reg;
            res.mean_reflectivity <= !valid ? 16'd0 : (neg_reg ? 16'(-qmag) : qmag);
            res.mean_valid <= valid;
            res.hit_fraction <= frac;
            res.too_few_scans <= few;
        end
endmodule

// ----- hw/rtl/radar_clutter_map_accumulator_top.sv -----
// Clutter map accumulator: a sample, merge or scan item passes through read,
// write back and return; a readout waits while the one bit-per-cycle
// divider forms the fraction and then the mean. After reset the block
// sweeps the gate memory before it accepts an item; configuration writes
// are taken at any time.
`include "radar_clutter_map_accumulator_top_defines.svh"
module radar_clutter_map_accumulator_top
    import rcm_pkg::*;
#(
    parameter int GATE_COUNT = 65536,
    parameter int MAX_SCANS  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    rcm_item_if.sink    in_ch,
    rcm_result_if.source out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    cfg_t cfg_reg;
    cmd_t cmd;
    status_t stat;
    logic [2:0] ridx;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.qen <= '0;
            cfg_reg.min_snr <= '0;
            cfg_reg.max_vel <= 15'd32767;
            cfg_reg.max_wid <= 16'hffff;
            cfg_reg.min_frac <= 16'd32768;
            cfg_reg.min_scans <= 13'd1;
            cfg_reg.imode <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_QEN:  cfg_reg.qen <= pwdata[2:0];
                REG_SNR:  cfg_reg.min_snr <= pwdata[15:0];
                REG_VEL:  cfg_reg.max_vel <= pwdata[14:0];
                REG_WID:  cfg_reg.max_wid <= pwdata[15:0];
                REG_FRAC: cfg_reg.min_frac <= pwdata[15:0];
                REG_MINS: cfg_reg.min_scans <= pwdata[12:0];
                REG_MODE: cfg_reg.imode <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_QEN:  prdata = {29'd0, cfg_reg.qen};
            REG_SNR:  prdata = {16'd0, cfg_reg.min_snr};
            REG_VEL:  prdata = {17'd0, cfg_reg.max_vel};
            REG_WID:  prdata = {16'd0, cfg_reg.max_wid};
            REG_FRAC: prdata = {16'd0, cfg_reg.min_frac};
            REG_MINS: prdata = {19'd0, cfg_reg.min_scans};
            REG_MODE: prdata = {31'd0, cfg_reg.imode};
            default:  prdata = '0;
        endcase
    end

    rcm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_action(in_ch.data.action), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    rcm_datapath #(.GATE_COUNT(GATE_COUNT), .MAX_SCANS(MAX_SCANS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg_reg), .item(in_ch.data),
        .stat(stat), .res(out_ch.data)
    );

    `RCM_ASSERT_NEVER(a_no_accept_while_full, clk, rst_n, out_ch.valid && in_ch.ready)
    `RCM_ASSERT(a_no_accept_clearing, clk, rst_n, !stat.clr_done |-> !in_ch.ready)
    `RCM_ASSERT(a_result_after_div, clk, rst_n, $rose(out_ch.valid) |-> $past(!stat.div_busy))
endmodule
